// ===== rtl/core/tisp_pkg.sv =====
// shared types, byte codes and result kinds of the telnet iac stream parser
package tisp_pkg;

  localparam int unsigned SUB_DEPTH_DEF = 64;

  localparam logic [7:0] BYTE_IAC = 8'hFF;
  localparam logic [7:0] BYTE_SB  = 8'd250;
  localparam logic [7:0] BYTE_SE  = 8'd240;

  localparam logic [2:0] KIND_APP_BYTE = 3'd0;
  localparam logic [2:0] KIND_APP_END  = 3'd1;
  localparam logic [2:0] KIND_COMMAND  = 3'd2;
  localparam logic [2:0] KIND_NEGOTIATE = 3'd3;
  localparam logic [2:0] KIND_SUB_BYTE = 3'd4;
  localparam logic [2:0] KIND_SUB_EMPTY = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] code;
    logic       last;
    logic       sub_overflow;
  } res_t;

  function automatic logic is_standalone(input logic [7:0] b);
    return b inside {8'd239, [8'd241:8'd249]};
  endfunction

endpackage

// ===== rtl/core/tisp_stream_if.sv =====
// valid/ready stream channel carrying one payload per beat
interface tisp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tisp_ram.sv =====
// generic single write port, single read port ram with registered read
module tisp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/core/tisp_ctrl.sv =====
// parser state machine, subnegotiation buffering and drain sequencing
module tisp_ctrl #(
  parameter int unsigned SUB_DEPTH = tisp_pkg::SUB_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  tisp_pkg::in_t                in_data_i,
  output logic                         in_ready_o,
  output logic                         res_valid_o,
  output tisp_pkg::res_t               res_o,
  input  logic                         res_ready_i,
  output logic                         mem_we_o,
  output logic [$clog2(SUB_DEPTH)-1:0] mem_waddr_o,
  output logic [7:0]                   mem_wdata_o,
  output logic                         mem_re_o,
  output logic [$clog2(SUB_DEPTH)-1:0] mem_raddr_o,
  input  logic [7:0]                   mem_rdata_i
);
  import tisp_pkg::*;

  localparam int unsigned AW = $clog2(SUB_DEPTH);
  localparam int unsigned CW = $clog2(SUB_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(SUB_DEPTH);

  typedef enum logic [2:0] {
    ST_DATA, ST_IAC, ST_NEG, ST_SBOPT, ST_SBDATA, ST_SBIAC
  } parse_e;

  typedef enum logic [1:0] {
    MD_RUN, MD_DRAIN, MD_TAIL
  } mode_e;

  parse_e        parse_q, parse_d;
  mode_e         mode_q, mode_d;
  logic [7:0]    pend_q, pend_d;
  logic [7:0]    opt_q, opt_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          app_q, app_d;
  logic          ovf_q, ovf_d;
  logic          tail_q, tail_d;

  logic          push;
  logic [7:0]    push_byte;
  logic          r1_valid;
  res_t          r1;
  logic          drain_start;
  logic          tail;
  logic [7:0]    b;

  assign b = in_data_i.data_byte;

  always_comb begin
    parse_d     = parse_q;
    mode_d      = mode_q;
    pend_d      = pend_q;
    opt_d       = opt_q;
    count_d     = count_q;
    idx_d       = idx_q;
    app_d       = app_q;
    ovf_d       = ovf_q;
    tail_d      = tail_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[AW-1:0];
    mem_wdata_o = 8'h00;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AW-1:0];
    push        = 1'b0;
    push_byte   = b;
    r1_valid    = 1'b0;
    r1          = '0;
    drain_start = 1'b0;
    tail        = 1'b0;

    case (mode_q)
      MD_RUN: begin
        in_ready_o = res_ready_i;
        if (in_valid_i && res_ready_i) begin
          case (parse_q)
            ST_IAC: begin
              parse_d = ST_DATA;
              if (b == BYTE_IAC) begin
                r1_valid = 1'b1;
                r1.kind  = KIND_APP_BYTE;
                r1.value = BYTE_IAC;
                app_d    = 1'b1;
              end else if (b == BYTE_SB) begin
                parse_d = ST_SBOPT;
              end else if (b == BYTE_SE) begin
                parse_d = ST_DATA;
              end else if (is_standalone(b)) begin
                r1_valid = 1'b1;
                r1.kind  = KIND_COMMAND;
                r1.code  = b;
              end else begin
                pend_d  = b;
                parse_d = ST_NEG;
              end
            end
            ST_NEG: begin
              r1_valid = 1'b1;
              r1.kind  = KIND_NEGOTIATE;
              r1.value = b;
              r1.code  = pend_q;
              parse_d  = ST_DATA;
            end
            ST_SBOPT: begin
              opt_d   = b;
              count_d = '0;
              ovf_d   = 1'b0;
              parse_d = ST_SBDATA;
            end
            ST_SBDATA: begin
              if (b == BYTE_IAC) begin
                parse_d = ST_SBIAC;
              end else begin
                push = 1'b1;
              end
            end
            ST_SBIAC: begin
              parse_d = ST_SBDATA;
              if (b == BYTE_IAC) begin
                push      = 1'b1;
                push_byte = BYTE_IAC;
              end else if (b == BYTE_SE) begin
                parse_d = ST_DATA;
                if (count_q == '0) begin
                  r1_valid        = 1'b1;
                  r1.kind         = KIND_SUB_EMPTY;
                  r1.code         = opt_q;
                  r1.sub_overflow = ovf_q;
                  ovf_d           = 1'b0;
                end else begin
                  drain_start = 1'b1;
                end
              end
            end
            default: begin
              if (b == BYTE_IAC) begin
                if (app_q) begin
                  r1_valid = 1'b1;
                  r1.kind  = KIND_APP_END;
                end
                app_d   = 1'b0;
                parse_d = ST_IAC;
              end else begin
                r1_valid = 1'b1;
                r1.kind  = KIND_APP_BYTE;
                r1.value = b;
                app_d    = 1'b1;
                parse_d  = ST_DATA;
              end
            end
          endcase

          tail = in_data_i.chunk_end && app_d;
          if (tail) begin
            app_d = 1'b0;
          end

          if (push) begin
            if (count_q < DEPTH_C) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = push_byte;
              count_d     = count_q + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end

          if (drain_start) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = '0;
            idx_d       = CW'(1);
            tail_d      = tail;
            mode_d      = MD_DRAIN;
          end else if (r1_valid) begin
            res_valid_o = 1'b1;
            res_o       = r1;
            res_o.last  = !tail;
            if (tail) begin
              mode_d = MD_TAIL;
            end
          end else if (tail) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_APP_END;
            res_o.last  = 1'b1;
          end
        end
      end
      MD_DRAIN: begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_SUB_BYTE;
        res_o.value        = mem_rdata_i;
        res_o.code         = opt_q;
        res_o.sub_overflow = ovf_q;
        res_o.last         = (idx_q == count_q) && !tail_q;
        if (res_ready_i) begin
          if (idx_q != count_q) begin
            mem_re_o = 1'b1;
            idx_d    = idx_q + CW'(1);
          end else begin
            count_d = '0;
            ovf_d   = 1'b0;
            mode_d  = tail_q ? MD_TAIL : MD_RUN;
          end
        end
      end
      MD_TAIL: begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_APP_END;
        res_o.last  = 1'b1;
        if (res_ready_i) begin
          mode_d = MD_RUN;
        end
      end
      default: begin
        mode_d = MD_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= ST_DATA;
      mode_q  <= MD_RUN;
      pend_q  <= 8'hFF;
      opt_q   <= 8'h00;
      count_q <= '0;
      idx_q   <= '0;
      app_q   <= 1'b0;
      ovf_q   <= 1'b0;
      tail_q  <= 1'b0;
    end else begin
      parse_q <= parse_d;
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      opt_q   <= opt_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      app_q   <= app_d;
      ovf_q   <= ovf_d;
      tail_q  <= tail_d;
    end
  end

  a_no_write_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MD_DRAIN) |-> !mem_we_o)
    else $error("sub buffer written while draining");

  a_drain_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MD_DRAIN) |-> (idx_q != '0 && idx_q <= count_q))
    else $error("drain index out of range");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("sub count beyond buffer depth");

  a_drain_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MD_DRAIN && !res_ready_i) |=> $stable(mem_rdata_i))
    else $error("stalled drain beat lost its byte");
endmodule

// ===== rtl/core/tisp_obuf.sv =====
// two-entry output buffer decoupling result generation from the sink
module tisp_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  tisp_pkg::res_t res_i,
  output logic           res_ready_o,
  output logic           out_valid_o,
  output tisp_pkg::res_t out_data_o,
  input  logic           out_ready_i
);
  import tisp_pkg::*;

  res_t       buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign res_ready_o = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[rptr_q];
  assign push        = res_valid_i && res_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule

// ===== rtl/core/telnet_iac_stream_parser_unit.sv =====
// telnet iac stream parser, top level
// Takes one received byte per beat and returns parsed beats: application
// bytes, block ends, commands, negotiations and subnegotiation runs, with
// last set on the final beat caused by each input byte. A byte that causes
// at most one result is taken with it; one that also closes a chunk of
// application data adds a block end beat that the next byte waits for.
// IAC SE ending a subnegotiation with buffered bytes holds the input while
// they leave the buffer RAM through its single read port, one per cycle
// while the output buffer has room. A two-beat buffer lets the parser run
// on while the sink stalls. The buffer RAM needs no clearing after reset.
module telnet_iac_stream_parser_unit #(
  parameter int unsigned SUB_DEPTH = tisp_pkg::SUB_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tisp_stream_if.sink   in_i,
  tisp_stream_if.source out_o
);
  import tisp_pkg::*;

  localparam int unsigned AW = $clog2(SUB_DEPTH);

  in_t           in_data;
  res_t          res;
  res_t          out_data;
  logic          res_valid, res_ready;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  assign in_data    = in_i.data;
  assign out_o.data = out_data;

  tisp_ctrl #(
    .SUB_DEPTH(SUB_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_data),
    .in_ready_o  (in_i.ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tisp_ram #(
    .WIDTH(8),
    .DEPTH(SUB_DEPTH)
  ) u_sub_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tisp_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_data),
    .out_ready_i (out_o.ready)
  );
endmodule
